// ===== src/cvle_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cvle_pkg
// Shared types and constants for the compacting value list engine: word
// layouts, command and status codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package cvle_pkg;

  localparam int DEPTH    = 64;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = 7;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DISPLAY = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MINMAX  = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic signed [DATA_W-1:0] operand_value;
  } cmd_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [CNT_W-1:0]         position;
    logic signed [DATA_W-1:0] result_value;
    logic signed [DATA_W-1:0] minimum_value;
    logic                     last;
  } rsp_item_t;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN, S_SHIFT} state_t;

  typedef enum logic [1:0] {RD_ZERO, RD_HOLD, RD_NEXT, RD_SKIP} rd_sel_t;
  typedef enum logic [1:0] {IDX_KEEP, IDX_CLEAR, IDX_INC} idx_op_t;
  typedef enum logic [1:0] {WR_NONE, WR_INSERT, WR_SHIFT} wr_sel_t;
  typedef enum logic [2:0] {
    RES_FULL, RES_EMPTY, RES_NOT_FOUND, RES_DONE, RES_FOUND, RES_DISPLAY, RES_MINMAX
  } res_t;

  typedef struct packed {
    logic    load;
    idx_op_t idx_op;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    mm_update;
    logic    push;
    res_t    res;
  } ctl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             count_zero;
    logic             full;
    logic             match;
    logic             at_last;
    logic             out_free;
    logic [CNT_W-1:0] count;
  } ctl_stat_t;

endpackage
`default_nettype wire

// ===== src/cvle_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cvle_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cvle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== src/cvle_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cvle_dp
// Datapath: entry store, entry count, walk index, running extremes, and the
// response register.
// ----------------------------------------------------------------------------
module cvle_dp
  import cvle_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cmd_item_t cmd_data,
  input  wire ctl_cmd_t  ctl,
  output ctl_stat_t      stat,
  output logic           rsp_valid,
  input  wire logic      rsp_ready,
  output rsp_item_t      rsp_data
);

  logic [CMD_W-1:0]         cmd_reg;
  logic [DATA_W-1:0]        operand_reg;
  logic [CNT_W-1:0]         count;
  logic [ADDR_W-1:0]        proc_idx;
  logic signed [DATA_W-1:0] mx;
  logic signed [DATA_W-1:0] mn;

  logic                     wr_en;
  logic [ADDR_W-1:0]        wr_addr;
  logic [DATA_W-1:0]        wr_data;
  logic [ADDR_W-1:0]        rd_addr;
  logic [DATA_W-1:0]        rd_data;
  logic signed [DATA_W-1:0] rd_s;
  logic signed [DATA_W-1:0] mx_cand;
  logic signed [DATA_W-1:0] mn_cand;
  logic [CNT_W-1:0]         pos;
  logic                     first;
  rsp_item_t                res_item;

  cvle_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    unique case (ctl.rd_sel)
      RD_ZERO: rd_addr = '0;
      RD_HOLD: rd_addr = proc_idx;
      RD_NEXT: rd_addr = proc_idx + ADDR_W'(1);
      RD_SKIP: rd_addr = proc_idx + ADDR_W'(2);
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    unique case (ctl.wr_sel)
      WR_INSERT: begin
        wr_en   = 1'b1;
        wr_addr = count[ADDR_W-1:0];
        wr_data = operand_reg;
      end
      WR_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = proc_idx;
        wr_data = rd_data;
      end
      default: begin
        wr_en   = 1'b0;
        wr_addr = proc_idx;
        wr_data = rd_data;
      end
    endcase
  end

  assign rd_s    = signed'(rd_data);
  assign first   = (proc_idx == '0);
  assign mx_cand = (first || rd_s > mx) ? rd_s : mx;
  assign mn_cand = (first || rd_s < mn) ? rd_s : mn;
  assign pos     = CNT_W'(proc_idx) + CNT_W'(1);

  always_comb begin
    stat.command    = cmd_reg;
    stat.count_zero = (count == '0);
    stat.full       = (count == CNT_W'(DEPTH));
    stat.match      = (rd_data == operand_reg);
    stat.at_last    = (pos == count);
    stat.out_free   = !rsp_valid || rsp_ready;
    stat.count      = count;
  end

  always_comb begin
    res_item = '0;
    res_item.last = 1'b1;
    unique case (ctl.res)
      RES_FULL:      res_item.status = STAT_FULL;
      RES_EMPTY:     res_item.status = STAT_EMPTY;
      RES_NOT_FOUND: res_item.status = STAT_NOT_FOUND;
      RES_DONE:      res_item.status = STAT_OK;
      RES_FOUND: begin
        res_item.status   = STAT_OK;
        res_item.position = pos;
      end
      RES_DISPLAY: begin
        res_item.status       = STAT_OK;
        res_item.position     = pos;
        res_item.result_value = rd_s;
        res_item.last         = stat.at_last;
      end
      RES_MINMAX: begin
        res_item.status        = STAT_OK;
        res_item.result_value  = mx_cand;
        res_item.minimum_value = mn_cand;
      end
      default: res_item.status = STAT_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_reg     <= cmd_data.command;
      operand_reg <= cmd_data.operand_value;
    end
    unique case (ctl.idx_op)
      IDX_CLEAR: proc_idx <= '0;
      IDX_INC:   proc_idx <= proc_idx + ADDR_W'(1);
      default:   proc_idx <= proc_idx;
    endcase
    if (ctl.mm_update) begin
      mx <= mx_cand;
      mn <= mn_cand;
    end
    if (ctl.push) begin
      rsp_data <= res_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (ctl.cnt_inc) begin
        count <= count + CNT_W'(1);
      end else if (ctl.cnt_dec) begin
        count <= count - CNT_W'(1);
      end
      if (ctl.push) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/cvle_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cvle_ctrl
// Controller: sequences one command at a time through dispatch, the entry
// walk and the delete compaction, and issues datapath commands.
// ----------------------------------------------------------------------------
module cvle_ctrl
  import cvle_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cmd_valid,
  output logic           cmd_ready,
  input  wire ctl_stat_t stat,
  output ctl_cmd_t       ctl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.command)
          CMD_INSERT: begin
            if (stat.out_free) begin
              state_next = S_IDLE;
            end
          end
          CMD_DELETE, CMD_SEARCH, CMD_DISPLAY, CMD_MINMAX: begin
            if (!stat.count_zero) begin
              state_next = S_SCAN;
            end else if (stat.out_free) begin
              state_next = S_IDLE;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_SCAN: begin
        unique case (stat.command)
          CMD_DISPLAY, CMD_MINMAX: begin
            if (stat.at_last && stat.out_free) begin
              state_next = S_IDLE;
            end
          end
          CMD_SEARCH: begin
            if ((stat.match || stat.at_last) && stat.out_free) begin
              state_next = S_IDLE;
            end
          end
          CMD_DELETE: begin
            if (stat.match) begin
              state_next = S_SHIFT;
            end else if (stat.at_last && stat.out_free) begin
              state_next = S_IDLE;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_SHIFT: begin
        if (stat.at_last && stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl        = '0;
    ctl.rd_sel = RD_HOLD;
    cmd_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd_ready  = 1'b1;
        ctl.load   = cmd_valid;
        ctl.rd_sel = RD_ZERO;
      end
      S_EXEC: begin
        ctl.rd_sel = RD_ZERO;
        ctl.idx_op = IDX_CLEAR;
        unique case (stat.command)
          CMD_INSERT: begin
            if (stat.out_free) begin
              ctl.push = 1'b1;
              if (stat.full) begin
                ctl.res = RES_FULL;
              end else begin
                ctl.res     = RES_DONE;
                ctl.wr_sel  = WR_INSERT;
                ctl.cnt_inc = 1'b1;
              end
            end
          end
          CMD_DELETE, CMD_SEARCH, CMD_DISPLAY, CMD_MINMAX: begin
            if (stat.count_zero && stat.out_free) begin
              ctl.push = 1'b1;
              ctl.res  = RES_EMPTY;
            end
          end
          default: ctl.push = 1'b0;
        endcase
      end
      S_SCAN: begin
        unique case (stat.command)
          CMD_DISPLAY: begin
            ctl.res = RES_DISPLAY;
            if (stat.out_free) begin
              ctl.push = 1'b1;
              if (!stat.at_last) begin
                ctl.rd_sel = RD_NEXT;
                ctl.idx_op = IDX_INC;
              end
            end
          end
          CMD_MINMAX: begin
            ctl.res = RES_MINMAX;
            if (stat.at_last) begin
              ctl.push = stat.out_free;
            end else begin
              ctl.mm_update = 1'b1;
              ctl.rd_sel    = RD_NEXT;
              ctl.idx_op    = IDX_INC;
            end
          end
          CMD_SEARCH: begin
            if (stat.match) begin
              ctl.res  = RES_FOUND;
              ctl.push = stat.out_free;
            end else if (stat.at_last) begin
              ctl.res  = RES_NOT_FOUND;
              ctl.push = stat.out_free;
            end else begin
              ctl.rd_sel = RD_NEXT;
              ctl.idx_op = IDX_INC;
            end
          end
          CMD_DELETE: begin
            if (stat.match) begin
              ctl.rd_sel = RD_NEXT;
            end else if (stat.at_last) begin
              ctl.res  = RES_NOT_FOUND;
              ctl.push = stat.out_free;
            end else begin
              ctl.rd_sel = RD_NEXT;
              ctl.idx_op = IDX_INC;
            end
          end
          default: ctl.push = 1'b0;
        endcase
      end
      S_SHIFT: begin
        ctl.res = RES_DONE;
        if (stat.at_last) begin
          if (stat.out_free) begin
            ctl.push    = 1'b1;
            ctl.cnt_dec = 1'b1;
          end
        end else begin
          ctl.wr_sel = WR_SHIFT;
          ctl.idx_op = IDX_INC;
          ctl.rd_sel = RD_SKIP;
        end
      end
      default: cmd_ready = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/compacting_value_list_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// compacting_value_list_engine
// Unsorted list of signed 32-bit values with insert, delete, search, display
// and min/max commands.
// ----------------------------------------------------------------------------
// The engine takes one command word at a time and returns its response words
// on the rsp channel in order; a response may wait in the output register
// while the next command is accepted. Search, min/max, display and delete walk
// the entries held, display pausing while a response waits in the output
// register, and a delete hit goes on into a compaction; the match search and
// the compaction that follows it together move through the entry RAM one
// address per cycle on its single read port. Reset needs no clearing pass.
module compacting_value_list_engine
  import cvle_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cmd_valid,
  output logic           cmd_ready,
  input  wire cmd_item_t cmd_data,
  output logic           rsp_valid,
  input  wire logic      rsp_ready,
  output rsp_item_t      rsp_data
);

  ctl_cmd_t  ctl;
  ctl_stat_t stat;

  cvle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  cvle_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd_data (cmd_data),
    .ctl      (ctl),
    .stat     (stat),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data (rsp_data)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stat.count <= CNT_W'(DEPTH))
    else $error("entry count exceeds capacity");

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    ctl.push |-> stat.out_free)
    else $error("response overwritten before it was taken");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    (ctl.wr_sel == WR_SHIFT) |-> !stat.at_last)
    else $error("compaction wrote past the last entry");

  a_delete_count: assert property (@(posedge clk) disable iff (rst)
    ctl.cnt_dec |=> (stat.count == $past(stat.count) - CNT_W'(1)))
    else $error("delete did not reduce the entry count by one");

endmodule
`default_nettype wire

// ===== verif/tb_compacting_value_list_engine.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_compacting_value_list_engine
// Self-checking bench for the value list engine. A short table of directed
// commands walks the empty list, the value extremes, duplicates, misses and
// the unused codes. Random commands then push the list up to full and back
// down to empty twice. Each response word is checked against the table's
// entry or a local model; both channels stall at random for most of the run.
// ----------------------------------------------------------------------------
module tb_compacting_value_list_engine;
  import cvle_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI  = 3'd7;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 32;
  localparam int SEGMENT_LEN [4] = '{95, 120, 95, 120};

  typedef struct packed {
    logic      typed;
    cmd_item_t word;
    rsp_item_t want;
  } directed_row_t;

  localparam rsp_item_t NO_WANT        = '0;
  localparam rsp_item_t WANT_OK        = '{STAT_OK, 7'd0, 32'sd0, 32'sd0, 1'b1};
  localparam rsp_item_t WANT_EMPTY     = '{STAT_EMPTY, 7'd0, 32'sd0, 32'sd0, 1'b1};
  localparam rsp_item_t WANT_NOT_FOUND = '{STAT_NOT_FOUND, 7'd0, 32'sd0, 32'sd0, 1'b1};
  localparam rsp_item_t WANT_EXTREMES  =
    '{STAT_OK, 7'd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1};

  localparam directed_row_t DIRECTED_PLAN [0:22] = '{
    '{1'b1, '{CMD_SEARCH,    32'sd0},         WANT_EMPTY},
    '{1'b1, '{CMD_DELETE,    32'sd0},         WANT_EMPTY},
    '{1'b1, '{CMD_DISPLAY,   32'sd0},         WANT_EMPTY},
    '{1'b1, '{CMD_MINMAX,    32'sd0},         WANT_EMPTY},
    '{1'b0, '{CMD_SPARE_LO,  32'sd9},         NO_WANT},
    '{1'b1, '{CMD_INSERT,    32'sh7FFF_FFFF}, WANT_OK},
    '{1'b1, '{CMD_INSERT,    32'sh8000_0000}, WANT_OK},
    '{1'b1, '{CMD_INSERT,    32'sd0},         WANT_OK},
    '{1'b1, '{CMD_INSERT,    -32'sd1},        WANT_OK},
    '{1'b1, '{CMD_INSERT,    32'sd5},         WANT_OK},
    '{1'b1, '{CMD_INSERT,    32'sd5},         WANT_OK},
    '{1'b0, '{CMD_SEARCH,    32'sd5},         NO_WANT},
    '{1'b1, '{CMD_MINMAX,    32'sd0},         WANT_EXTREMES},
    '{1'b0, '{CMD_DISPLAY,   32'sd0},         NO_WANT},
    '{1'b1, '{CMD_SEARCH,    32'sd1234},      WANT_NOT_FOUND},
    '{1'b1, '{CMD_DELETE,    32'sd1234},      WANT_NOT_FOUND},
    '{1'b0, '{CMD_DELETE,    32'sd5},         NO_WANT},
    '{1'b0, '{CMD_SEARCH,    32'sd5},         NO_WANT},
    '{1'b0, '{CMD_DELETE,    32'sh7FFF_FFFF}, NO_WANT},
    '{1'b0, '{CMD_SPARE_MID, 32'sh8000_0000}, NO_WANT},
    '{1'b0, '{CMD_DISPLAY,   32'sh7FFF_FFFF}, NO_WANT},
    '{1'b0, '{CMD_SPARE_HI,  -32'sd1},        NO_WANT},
    '{1'b0, '{CMD_MINMAX,    -32'sd1},        NO_WANT}
  };

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_ready;
  cmd_item_t cmd_data  = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_item_t rsp_data;

  logic signed [DATA_W-1:0] list_vals [DEPTH];
  int        list_count   = 0;
  int        deepest_list = 0;
  rsp_item_t fresh_words [$];
  rsp_item_t expected_words [$];

  int cycle_count    = 0;
  int mismatch_count = 0;
  int words_checked  = 0;
  int sent_count     = 0;
  int spare_count    = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int send_idle_pct  = 38;
  int recv_idle_pct  = 84;

  compacting_value_list_engine dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd_data (cmd_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data (rsp_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic apply_command(input cmd_item_t w);
    rsp_item_t r;
    int i;
    int hit;
    logic signed [DATA_W-1:0] hi;
    logic signed [DATA_W-1:0] lo;
    fresh_words.delete();
    r = '0;
    r.last = 1'b1;
    hit = list_count;
    for (i = list_count - 1; i >= 0; i--)
      if (list_vals[i] == w.operand_value) hit = i;
    if (w.command > CMD_MINMAX) return;
    if (w.command == CMD_INSERT) begin
      if (list_count >= DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        list_vals[list_count] = w.operand_value;
        list_count++;
      end
      fresh_words.push_back(r);
    end else if (list_count == 0) begin
      r.status = STAT_EMPTY;
      fresh_words.push_back(r);
    end else begin
      case (w.command)
        CMD_DELETE: begin
          if (hit == list_count) begin
            r.status = STAT_NOT_FOUND;
          end else begin
            for (i = hit; i < list_count - 1; i++) list_vals[i] = list_vals[i + 1];
            list_count--;
          end
          fresh_words.push_back(r);
        end
        CMD_SEARCH: begin
          if (hit == list_count) r.status = STAT_NOT_FOUND;
          else r.position = CNT_W'(hit + 1);
          fresh_words.push_back(r);
        end
        CMD_DISPLAY: begin
          for (i = 0; i < list_count; i++) begin
            r.position     = CNT_W'(i + 1);
            r.result_value = list_vals[i];
            r.last         = (i == list_count - 1);
            fresh_words.push_back(r);
          end
        end
        default: begin
          hi = list_vals[0];
          lo = list_vals[0];
          for (i = 1; i < list_count; i++) begin
            if (list_vals[i] > hi) hi = list_vals[i];
            if (list_vals[i] < lo) lo = list_vals[i];
          end
          r.result_value  = hi;
          r.minimum_value = lo;
          fresh_words.push_back(r);
        end
      endcase
    end
    if (list_count > deepest_list) deepest_list = list_count;
  endtask

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
    $display("MISMATCH cycle %0d: %s expected 'h%0h, got 'h%0h", cycle_count, what, want, got);
    mismatch_count++;
  endtask

  task automatic check_word(input rsp_item_t got);
    rsp_item_t want;
    words_checked++;
    status_seen[got.status]++;
    if (expected_words.size() == 0) begin
      report_mismatch("response word with nothing pending, status", '0,
                      DATA_W'(got.status));
      return;
    end
    want = expected_words.pop_front();
    if (got.status !== want.status)
      report_mismatch("status", DATA_W'(want.status), DATA_W'(got.status));
    if (got.position !== want.position)
      report_mismatch("position", DATA_W'(want.position), DATA_W'(got.position));
    if (got.result_value !== want.result_value)
      report_mismatch("result_value", want.result_value, got.result_value);
    if (got.minimum_value !== want.minimum_value)
      report_mismatch("minimum_value", want.minimum_value, got.minimum_value);
    if (got.last !== want.last)
      report_mismatch("last", DATA_W'(want.last), DATA_W'(got.last));
  endtask

  task automatic send_word(input directed_row_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_data  <= row.word;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    apply_command(row.word);
    if (row.typed) expected_words.push_back(row.want);
    else foreach (fresh_words[k]) expected_words.push_back(fresh_words[k]);
    if (row.word.command > CMD_MINMAX) spare_count++;
    sent_count++;
    if (sent_count == 160) begin
      send_idle_pct = 84;
      recv_idle_pct = 38;
    end else if (sent_count == 320) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    @(negedge clk);
  endtask

  function automatic logic [CMD_W-1:0] pick_command(input bit grow);
    int roll;
    roll = $urandom_range(99);
    if (grow) begin
      if (roll < 78) return CMD_INSERT;
      if (roll < 84) return CMD_DELETE;
      if (roll < 90) return CMD_SEARCH;
      if (roll < 94) return CMD_DISPLAY;
      if (roll < 97) return CMD_MINMAX;
    end else begin
      if (roll < 5) return CMD_INSERT;
      if (roll < 65) return CMD_DELETE;
      if (roll < 78) return CMD_SEARCH;
      if (roll < 86) return CMD_DISPLAY;
      if (roll < 95) return CMD_MINMAX;
    end
    return CMD_SPARE_LO + CMD_W'($urandom_range(2));
  endfunction

  function automatic logic signed [DATA_W-1:0] random_operand(input bit lookup,
                                                               input int hit_pct);
    if (lookup && list_count > 0 && $urandom_range(99) < hit_pct)
      return list_vals[$urandom_range(list_count - 1)];
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      1, 2, 3: return $signed($urandom_range(8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) check_word(rsp_data);
  end

  initial begin
    forever begin
      @(negedge clk);
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    directed_row_t row;
    int seg;
    int in_seg;
    bit grow;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    foreach (DIRECTED_PLAN[k]) send_word(DIRECTED_PLAN[k]);
    for (seg = 0; seg < 4; seg++) begin
      grow   = (seg % 2 == 0);
      in_seg = 0;
      while (in_seg < SEGMENT_LEN[seg]) begin
        row = '0;
        row.word.command       = pick_command(grow);
        row.word.operand_value = random_operand(row.word.command != CMD_INSERT,
                                                grow ? 70 : 95);
        send_word(row);
        if (row.word.command <= CMD_MINMAX) in_seg++;
      end
    end
    cmd_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d command words (%0d with unused codes), checked %0d response words.",
             sent_count, spare_count, words_checked);
    $display("Statuses ok/full/empty/not-found: %0d/%0d/%0d/%0d; longest list %0d entries.",
             status_seen[STAT_OK], status_seen[STAT_FULL], status_seen[STAT_EMPTY],
             status_seen[STAT_NOT_FOUND], deepest_list);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
